// ----- rtl/fenwick_prefix_sum_table_assert.svh -----
// ----------------------------------------------------------------------------
// fenwick prefix sum table assertion macros
// concurrent checks on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef FENWICK_PREFIX_SUM_TABLE_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FPS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fenwick table check failed");

// next-cycle implication
`define FPS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fenwick table check failed");

`else

`define FPS_ASSERT_IMP(label, ante, cons)

`define FPS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- rtl/fps_pkg.sv -----
// ----------------------------------------------------------------------------
// fps_pkg
// shared widths, state encoding and controller/datapath bundles
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int POS_W  = 11;
   localparam int DATA_W = 32;
   // walk index: up to twice the largest size in use
   localparam int IDX_W  = 12;

   localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_HI,
      ST_Q_LO,
      ST_Q_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic add_read;
      logic add_write;
      logic walk_hi;
      logic walk_lo;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic op_query;
      logic add_skip;
      logic query_empty;
      logic add_last;
      logic down_last;
      logic low_zero;
      logic pend;
      logic rsp_free;
   } status_type;

   function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
      return v & (~v + 1'b1);
   endfunction

endpackage

// ----- rtl/fps_req_if.sv -----
// ----------------------------------------------------------------------------
// fps_req_if
// request channel: add or range query beat
// ----------------------------------------------------------------------------
interface fps_req_if import fps_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] delta;
   logic [POS_W-1:0]         range_low;
   logic [POS_W-1:0]         range_high;

   modport source (
      output valid, operation, position, delta, range_low, range_high,
      input  ready
   );

   modport sink (
      input  valid, operation, position, delta, range_low, range_high,
      output ready
   );

endinterface

// ----- rtl/fps_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fps_rsp_if
// response channel: one range sum beat per query
// ----------------------------------------------------------------------------
interface fps_rsp_if import fps_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] range_sum;

   modport source (
      output valid, range_sum,
      input  ready
   );

   modport sink (
      input  valid, range_sum,
      output ready
   );

endinterface

// ----- rtl/fps_ram.sv -----
// ----------------------------------------------------------------------------
// fps_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fps_ctrl.sv -----
// ----------------------------------------------------------------------------
// fps_ctrl
// sequencer for clearing pass, add walks and two-chain range queries
// ----------------------------------------------------------------------------
module fps_ctrl import fps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (!status.op_query) begin
               state_in = status.add_skip ? ST_IDLE : ST_ADD_RD;
            end else begin
               state_in = status.query_empty ? ST_Q_DONE : ST_Q_HI;
            end
         end
         ST_ADD_RD: begin
            cmd.add_read = 1'b1;
            state_in     = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cmd.add_write = 1'b1;
            state_in      = status.add_last ? ST_IDLE : ST_ADD_RD;
         end
         ST_Q_HI: begin
            cmd.walk_hi = 1'b1;
            if (status.down_last) begin
               state_in = status.low_zero ? ST_Q_DONE : ST_Q_LO;
            end
         end
         ST_Q_LO: begin
            cmd.walk_lo = 1'b1;
            if (status.down_last) begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_DONE: begin
            // wait for the last node to land in the accumulator and for the response register to be free
            if (!status.pend && status.rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`include "fenwick_prefix_sum_table_assert.svh"

   `FPS_ASSERT_NXT(a_clear_done, state_ff == ST_CLEAR && status.clear_last, state_ff == ST_IDLE)
   `FPS_ASSERT_IMP(a_wr_after_rd, state_ff == ST_ADD_WR, $past(state_ff) == ST_ADD_RD)
   `FPS_ASSERT_IMP(a_load_settled, cmd.result_load, !status.pend && status.rsp_free)

endmodule

// ----- rtl/fps_dpath.sv -----
// ----------------------------------------------------------------------------
// fps_dpath
// tree node store, walk index, accumulator and response register
// ----------------------------------------------------------------------------
module fps_dpath import fps_pkg::*; #(
   parameter int SIZE = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     req_operation,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_delta,
   input  logic [POS_W-1:0]         req_range_low,
   input  logic [POS_W-1:0]         req_range_high,
   input  logic                     csr_wr_en,
   input  logic [POS_W-1:0]         csr_wr_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_range_sum
);

   localparam int AW = $clog2(SIZE);

   // control state
   logic [POS_W-1:0]  size_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic              pend_ff;
   logic              rsp_valid_ff;

   // payload
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  low_m1_ff;
   logic [IDX_W-1:0]  limit_ff;
   logic [DATA_W-1:0] delta_ff;
   logic [DATA_W-1:0] acc_ff;
   logic              sub_ff;
   logic              op_ff;
   logic              empty_ff;
   logic              skip_ff;
   logic [DATA_W-1:0] sum_ff;

   logic [IDX_W-1:0]    limit;
   logic [IDX_W-1:0]    pos_e;
   logic [IDX_W-1:0]    hi_e;
   logic [IDX_W-1:0]    hi_cl;
   logic [IDX_W-1:0]    lo_cl;
   logic [IDX_W-1:0]    idx_up;
   logic [IDX_W-1:0]    idx_down;
   logic [IDX_W-1:0]    idx_m1;
   logic [AW+IDX_W-1:0] addr_wide;
   logic [AW-1:0]       node_addr;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [DATA_W-1:0]   ram_wr_data;
   logic [DATA_W-1:0]   ram_rd_data;
   logic                rsp_free;

   // a size register above the store depth acts as the depth
   assign limit = (32'(size_ff) > SIZE) ? IDX_W'(SIZE) : IDX_W'(size_ff);

   assign pos_e = IDX_W'(req_position);
   assign hi_e  = IDX_W'(req_range_high);
   assign hi_cl = (hi_e > limit) ? limit : hi_e;
   assign lo_cl = (req_range_low == '0) ? IDX_W'(1) : IDX_W'(req_range_low);

   assign idx_up   = idx_ff + low_bit(idx_ff);
   assign idx_down = idx_ff - low_bit(idx_ff);

   // nodes 1..SIZE live at addresses 0..SIZE-1
   assign idx_m1    = idx_ff - 1'b1;
   assign addr_wide = {{AW{1'b0}}, idx_m1};
   assign node_addr = addr_wide[AW-1:0];

   assign ram_wr_en   = cmd.clear_step | cmd.add_write;
   assign ram_wr_addr = cmd.clear_step ? clr_cnt_ff : node_addr;
   assign ram_wr_data = cmd.clear_step ? '0 : ram_rd_data + delta_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fps_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SIZE)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (node_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         pend_ff <= cmd.walk_hi | cmd.walk_lo;
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_operation;
         delta_ff  <= DATA_W'(req_delta);
         limit_ff  <= limit;
         low_m1_ff <= lo_cl - 1'b1;
         empty_ff  <= lo_cl > hi_cl;
         skip_ff   <= (pos_e == '0) || (pos_e > limit);
         idx_ff    <= (req_operation == OP_QUERY) ? hi_cl : pos_e;
      end else if (cmd.add_write) begin
         idx_ff <= idx_up;
      end else if (cmd.walk_hi) begin
         // high chain done: restart from the node below the range
         idx_ff <= (idx_down == '0) ? low_m1_ff : idx_down;
      end else if (cmd.walk_lo) begin
         idx_ff <= idx_down;
      end

      if (cmd.walk_hi || cmd.walk_lo) begin
         sub_ff <= cmd.walk_lo;
      end

      if (cmd.accept) begin
         acc_ff <= '0;
      end else if (pend_ff) begin
         acc_ff <= sub_ff ? acc_ff - ram_rd_data : acc_ff + ram_rd_data;
      end

      if (cmd.result_load) begin
         sum_ff <= acc_ff;
      end
   end

   always_comb begin
      status             = '0;
      status.clear_last  = clr_cnt_ff == AW'(SIZE - 1);
      status.op_query    = op_ff == OP_QUERY;
      status.add_skip    = skip_ff;
      status.query_empty = empty_ff;
      status.add_last    = idx_up > limit_ff;
      status.down_last   = idx_down == '0;
      status.low_zero    = low_m1_ff == '0;
      status.pend        = pend_ff;
      status.rsp_free    = rsp_free;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = sum_ff;

`include "fenwick_prefix_sum_table_assert.svh"

   `FPS_ASSERT_IMP(a_idx_range, cmd.add_read || cmd.walk_hi || cmd.walk_lo, idx_ff != '0 && 32'(idx_ff) <= SIZE)
   `FPS_ASSERT_NXT(a_rsp_set, cmd.result_load, rsp_valid_ff && sum_ff == $past(acc_ff))

endmodule

// ----- rtl/fenwick_prefix_sum_table.sv -----
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table
// binary indexed tree of SIZE 32-bit counters with point add and range sum
// ----------------------------------------------------------------------------
//  channel   direction  payload                                   beats
//  req_if    in         operation position delta range_low/high   one per item
//  rsp_if    out        range_sum                                 one per query
//  csr_*     in         size_in_use (write only)                  -
//
//  after reset a clearing pass writes zero to all SIZE nodes, one per cycle,
//  before the first request beat is taken
//  an add passes through acceptance and setup, then a node read and a node
//  write for each visited node, up to 11 nodes at SIZE 1024; the single
//  node ram port pair sets this order
//  a query passes through acceptance and setup, takes each node of the two
//  prefix chains in turn (up to 20 nodes at SIZE 1024), then settles the accumulator
//  one item is in work at a time; a finished sum waits in the output register
//  while the next beat is taken, and a query ending stalls only if it is full
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table import fps_pkg::*; #(
   parameter int SIZE = 1024
) (
   input  logic             clock,
   input  logic             reset,
   fps_req_if.sink          req_if,
   fps_rsp_if.source        rsp_if,
   input  logic             csr_wr_en,
   input  logic [POS_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   fps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fps_dpath #(
      .SIZE (SIZE)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_if.operation),
      .req_position   (req_if.position),
      .req_delta      (req_if.delta),
      .req_range_low  (req_if.range_low),
      .req_range_high (req_if.range_high),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_range_sum  (rsp_if.range_sum)
   );

   assign req_if.ready = req_ready;

endmodule
